>>> rtl/gpr_pkg.sv
// Shared types and constants for the 5x5 binomial pyramid reduce block.
package gpr_pkg;

   // Default line store depth and height limit
   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int HEIGHT_LIMIT      = 4096;

   // Result queue between front and back
   localparam int QUEUE_DEPTH = 8;
   localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int CSR_DATA_W = 13;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROUND_MODE   = 2'd2;

   localparam logic [12:0] RESET_FRAME_WIDTH  = 13'd640;
   localparam logic [12:0] RESET_FRAME_HEIGHT = 13'd480;
   localparam logic        RESET_ROUND_MODE   = 1'b1;

   // One reduced pixel with its position flags
   typedef struct packed {
      logic [7:0] pixel;
      logic       row_end;
      logic       frame_end;
   } result_type;

   // All results caused by one source pixel
   typedef struct packed {
      logic [2:0]            count;
      result_type [3:0]      slot;
   } entry_type;

endpackage

>>> rtl/gpr_front.sv
// Front: pixel intake, line stores, vertical sums, column windows, result forming.
module gpr_front
   import gpr_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_pixel_in,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic [QCW-1:0]         q_count,
   output logic                   push,
   output entry_type              push_entry
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int GW = (AW + 1 > CSR_DATA_W) ? AW + 1 : CSR_DATA_W;

   // Configuration and position
   logic [12:0]   frame_width_ff, frame_height_ff;
   logic          round_mode_ff;
   logic [AW-1:0] col_ff;
   logic [11:0]   row_ff;

   logic [GW-1:0] w_ext, w_eff, w_last;
   logic [12:0]   h_eff, h_last;
   logic          acc, lcol, lrow;

   // Stage 1
   logic          s1_v_ff, s1_row0_ff, s1_even_ff, s1_lrow_ff, s1_lcol_ff;
   logic [7:0]    s1_pix_ff;
   logic [AW-1:0] s1_col_ff;
   logic [7:0]    ctr_q_ff, odd_q_ff;
   logic [10:0]   ps_q_ff;
   logic          byp_ctr_ff, byp_odd_ff, byp_ps_ff;
   logic [7:0]    byp_ctr_d_ff, byp_odd_d_ff;
   logic [10:0]   byp_ps_d_ff;

   logic [7:0]    ctr_mem [MAX_WIDTH];
   logic [7:0]    odd_mem [MAX_WIDTH];
   logic [10:0]   ps_mem  [MAX_WIDTH];

   logic [7:0]    ctr, odd;
   logic [10:0]   ps;
   logic          ctr_we, odd_we, ps_we;
   logic [10:0]   ps_wd;
   logic [11:0]   v0, v1;
   logic          act0, act1;

   logic [11:0]   win_ff [2][5];

   // Stage 2
   logic          s2_v_ff, s2_int_ff, s2_lcol_ff, s2_even_ff;
   logic [1:0]    s2_act_ff, s2_fin_ff;

   logic [QCW:0]  busy;

   // Weighted 1-4-6-4-1 sum, divide by 256, saturate
   function automatic logic [7:0] weigh(input logic [11:0] a, input logic [11:0] b,
                                        input logic [11:0] c, input logic [11:0] d,
                                        input logic [11:0] e, input logic rnd);
      logic [16:0] s;
      logic [16:0] q;
      s = 17'(a) + 17'(e) + (17'(b) + 17'(d)) * 17'd4 + 17'(c) * 17'd6;
      q = rnd ? ((s + 17'd128) >> 8) : (s >> 8);
      if (q > 17'd255) begin
         q = 17'd255;
      end
      return q[7:0];
   endfunction

   // Effective geometry
   always_comb begin
      w_ext = GW'(frame_width_ff);
      if (w_ext == '0) begin
         w_eff = GW'(1);
      end else if (w_ext > GW'(MAX_WIDTH)) begin
         w_eff = GW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      w_last = w_eff - GW'(1);
      if (frame_height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (frame_height_ff > 13'(HEIGHT_LIMIT)) begin
         h_eff = 13'(HEIGHT_LIMIT);
      end else begin
         h_eff = frame_height_ff;
      end
      h_last = h_eff - 13'd1;
   end

   assign lcol = (col_ff == w_last[AW-1:0]);
   assign lrow = (row_ff == h_last[11:0]);

   // Hold intake while the queue could not take every pixel in flight
   assign busy = (QCW+1)'(q_count) + (QCW+1)'(s1_v_ff) + (QCW+1)'(s2_v_ff);
   assign req_stall = (busy >= (QCW+1)'(QUEUE_DEPTH));
   assign acc = req_valid && !req_stall;

   // Configuration writes and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
         round_mode_ff   <= RESET_ROUND_MODE;
         col_ff          <= '0;
         row_ff          <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_write_data;
               col_ff <= '0;
               row_ff <= '0;
            end
            REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_write_data;
               col_ff <= '0;
               row_ff <= '0;
            end
            REG_ROUND_MODE: begin
               round_mode_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end else if (acc) begin
         if (lcol) begin
            col_ff <= '0;
            row_ff <= lrow ? 12'd0 : row_ff + 12'd1;
         end else begin
            col_ff <= col_ff + AW'(1);
         end
      end
   end

   // Advance stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= acc;
      end
   end

   // Capture the pixel and its position flags
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff  <= req_pixel_in;
         s1_col_ff  <= col_ff;
         s1_row0_ff <= (row_ff == 12'd0);
         s1_even_ff <= !row_ff[0] && (row_ff != 12'd0);
         s1_lrow_ff <= lrow;
         s1_lcol_ff <= lcol;
         byp_ctr_ff   <= ctr_we && (s1_col_ff == col_ff);
         byp_odd_ff   <= odd_we && (s1_col_ff == col_ff);
         byp_ps_ff    <= ps_we && (s1_col_ff == col_ff);
         byp_ctr_d_ff <= s1_pix_ff;
         byp_odd_d_ff <= s1_pix_ff;
         byp_ps_d_ff  <= ps_wd;
      end
   end

   // Line stores: read on intake, written in the cycle after
   always_ff @(posedge clock) begin
      if (acc) begin
         ctr_q_ff <= ctr_mem[col_ff];
         odd_q_ff <= odd_mem[col_ff];
         ps_q_ff  <= ps_mem[col_ff];
      end
      if (ctr_we) begin
         ctr_mem[s1_col_ff] <= s1_pix_ff;
      end
      if (odd_we) begin
         odd_mem[s1_col_ff] <= s1_pix_ff;
      end
      if (ps_we) begin
         ps_mem[s1_col_ff] <= ps_wd;
      end
   end

   // Vertical sums by row class
   always_comb begin
      ctr = byp_ctr_ff ? byp_ctr_d_ff : ctr_q_ff;
      odd = byp_odd_ff ? byp_odd_d_ff : odd_q_ff;
      ps  = byp_ps_ff  ? byp_ps_d_ff  : ps_q_ff;
      ctr_we = 1'b0;
      odd_we = 1'b0;
      ps_we  = 1'b0;
      ps_wd  = 11'(ctr) + 11'(odd) * 11'd4;
      v0 = '0;
      v1 = '0;
      act0 = 1'b0;
      act1 = 1'b0;
      if (s1_row0_ff) begin
         ctr_we = s1_v_ff;
         ps_we  = s1_v_ff;
         ps_wd  = 11'(s1_pix_ff) * 11'd5;
         v0     = {s1_pix_ff, 4'b0000};
         act0   = s1_lrow_ff;
      end else if (s1_even_ff) begin
         ctr_we = s1_v_ff;
         ps_we  = s1_v_ff;
         v0 = 12'(s1_pix_ff) + 12'(odd) * 12'd4 + 12'(ctr) * 12'd6 + 12'(ps);
         v1 = 12'(ps_wd) + 12'(s1_pix_ff) * 12'd11;
         act0 = 1'b1;
         act1 = s1_lrow_ff;
      end else begin
         odd_we = s1_v_ff;
         v0 = 12'(ps) + 12'(ctr) * 12'd6 + 12'(s1_pix_ff) * 12'd5;
         act0 = s1_lrow_ff;
      end
   end

   // Column windows, one per lane
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < 5; k++) begin
               win_ff[l][k] <= '0;
            end
         end
      end else if (s1_v_ff) begin
         if (act0) begin
            for (int k = 0; k < 5; k++) begin
               win_ff[0][k] <= (s1_col_ff == '0 || k == 4) ? v0 : win_ff[0][(k+1)%5];
            end
         end
         if (act1) begin
            for (int k = 0; k < 5; k++) begin
               win_ff[1][k] <= (s1_col_ff == '0 || k == 4) ? v1 : win_ff[1][(k+1)%5];
            end
         end
      end
   end

   // Advance stage 2 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         s2_int_ff  <= !s1_col_ff[0] && (s1_col_ff >= AW'(2));
         s2_even_ff <= !s1_col_ff[0];
         s2_lcol_ff <= s1_lcol_ff;
         s2_act_ff  <= {act1, act0};
         s2_fin_ff  <= {s1_lrow_ff, s1_lrow_ff && !act1};
      end
   end

   // Form interior and edge results, packed in order
   always_comb begin
      result_type cand [4];
      logic [3:0] en;
      logic [2:0] cnt;
      for (int l = 0; l < 2; l++) begin
         cand[2*l].pixel = weigh(win_ff[l][0], win_ff[l][1], win_ff[l][2],
                                 win_ff[l][3], win_ff[l][4], round_mode_ff);
         cand[2*l].row_end   = 1'b0;
         cand[2*l].frame_end = 1'b0;
         en[2*l] = s2_act_ff[l] && s2_int_ff;
         if (s2_even_ff) begin
            cand[2*l+1].pixel = weigh(win_ff[l][2], win_ff[l][3], win_ff[l][4],
                                      win_ff[l][4], win_ff[l][4], round_mode_ff);
         end else begin
            cand[2*l+1].pixel = weigh(win_ff[l][1], win_ff[l][2], win_ff[l][3],
                                      win_ff[l][4], win_ff[l][4], round_mode_ff);
         end
         cand[2*l+1].row_end   = 1'b1;
         cand[2*l+1].frame_end = s2_fin_ff[l];
         en[2*l+1] = s2_act_ff[l] && s2_lcol_ff;
      end
      cnt = '0;
      push_entry = '0;
      for (int k = 0; k < 4; k++) begin
         if (en[k]) begin
            push_entry.slot[cnt[1:0]] = cand[k];
            cnt = cnt + 3'd1;
         end
      end
      push_entry.count = cnt;
      push = s2_v_ff && (cnt != 3'd0);
   end

endmodule

>>> rtl/gpr_queue.sv
// Short queue of result groups between front and back.
module gpr_queue
   import gpr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  entry_type      push_entry,
   input  logic           pop,
   output entry_type      head,
   output logic [QCW-1:0] count
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [QCW-1:0]  count_ff;

   assign head  = slot_ff[rd_ff];
   assign count = count_ff;

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         count_ff <= count_ff + QCW'(push) - QCW'(pop);
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/gpr_back.sv
// Back: deliver each queued result group one beat at a time.
module gpr_back
   import gpr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  entry_type      head,
   input  logic [QCW-1:0] count,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_pixel_out,
   output logic           rsp_last_in_row,
   output logic           rsp_last_in_frame
);

   logic [1:0] idx_ff;
   logic       take, last;
   result_type cur;

   assign rsp_valid = (count != '0);
   assign cur       = head.slot[idx_ff];
   assign rsp_pixel_out     = cur.pixel;
   assign rsp_last_in_row   = cur.row_end;
   assign rsp_last_in_frame = cur.frame_end;

   assign take = rsp_valid && !rsp_stall;
   assign last = ({1'b0, idx_ff} == head.count - 3'd1);
   assign pop  = take && last;

   // Step through the group, drop it after its last beat
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (take) begin
         idx_ff <= last ? 2'd0 : idx_ff + 2'd1;
      end
   end

endmodule

>>> rtl/gaussian_pyramid_reduce_5x5_top.sv
// Top level of the 5x5 binomial pyramid reduce block.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_pixel_in
//   rsp_     out        rsp_valid/rsp_stall  rsp_pixel_out, rsp_last_in_row, rsp_last_in_frame
//   csr_     in         csr_write_enable     csr_index, csr_write_data
//
// One source pixel is taken per cycle unless req_stall is high; results leave one per cycle
// unless rsp_stall is high, after store read, vertical sum, horizontal sum and result queue.
// A right-edge pixel or a pixel of the last row of an odd-height frame gives up
// to two results, four at that row's right edge, set out one beat per cycle unless stalled.
// Intake stalls when the eight-entry result queue could not hold every pixel in flight.
// Reset clears control and windows; line stores need no clearing pass, rows 0 and 1 fill them.
module gaussian_pyramid_reduce_5x5_top
   import gpr_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_pixel_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_pixel_out,
   output logic                   rsp_last_in_row,
   output logic                   rsp_last_in_frame,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic           push, pop;
   entry_type      push_entry, head;
   logic [QCW-1:0] q_count;

   gpr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_in     (req_pixel_in),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_count          (q_count),
      .push             (push),
      .push_entry       (push_entry)
   );

   gpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .count      (q_count)
   );

   gpr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .count             (q_count),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_last_in_row   (rsp_last_in_row),
      .rsp_last_in_frame (rsp_last_in_frame)
   );

endmodule

>>> rtl/gpr_checker.sv
// Port-level checks for the pyramid reduce top level, with its bind.
module gpr_checker
   import gpr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [7:0]             req_pixel_in,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [7:0]             rsp_pixel_out,
   input logic                   rsp_last_in_row,
   input logic                   rsp_last_in_frame,
   input logic                   csr_write_enable,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
         && $stable(rsp_last_in_row) && $stable(rsp_last_in_frame))
      else $error("stalled result beat changed");

   // Frame end only on a row end
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_in_frame |-> rsp_last_in_row)
      else $error("frame end without row end");

   // Nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // Intake open right after reset
   a_reset_open: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("intake stalled right after reset");

endmodule

bind gaussian_pyramid_reduce_5x5_top gpr_checker u_gpr_checker (.*);

>>> verif/gaussian_pyramid_reduce_5x5_top_test.sv
// Self-checking testbench for the 5x5 binomial pyramid reduce block.
module gaussian_pyramid_reduce_5x5_top_test;
   import gpr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = DEFAULT_MAX_WIDTH;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PIXELS = 340;
   localparam int CLAMP_PIXELS = 24;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   // Pyramid predictor: own copy of geometry, line stores and column window
   class reduce_scoreboard;
      int unsigned frame_width;
      int unsigned frame_height;
      bit round_mode;
      int unsigned center_line [LINE_DEPTH];
      int unsigned partial_line [LINE_DEPTH];
      int unsigned odd_line [LINE_DEPTH];
      int unsigned window [2][5];
      int unsigned col_pos;
      int unsigned row_pos;
      result_type pending_pixels[$];
      int mismatches;

      function new();
         frame_width = RESET_FRAME_WIDTH;
         frame_height = RESET_FRAME_HEIGHT;
         round_mode = RESET_ROUND_MODE;
         foreach (center_line[i]) begin
            center_line[i] = 0;
            partial_line[i] = 0;
            odd_line[i] = 0;
         end
         foreach (window[l, k]) window[l][k] = 0;
         col_pos = 0;
         row_pos = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_FRAME_WIDTH: begin
               frame_width = data;
               col_pos = 0;
               row_pos = 0;
            end
            REG_FRAME_HEIGHT: begin
               frame_height = data;
               col_pos = 0;
               row_pos = 0;
            end
            REG_ROUND_MODE: round_mode = data[0];
            default: ;
         endcase
      endfunction

      // Weight five column sums 1-4-6-4-1 and scale down by 256
      function void emit(int unsigned a, int unsigned b, int unsigned c, int unsigned d,
                         int unsigned e, bit row_end, bit frame_end);
         int unsigned s;
         int unsigned q;
         result_type r;
         s = a + e + 4 * (b + d) + 6 * c;
         q = round_mode ? ((s + 128) >> 8) : (s >> 8);
         if (q > 255) q = 255;
         r.pixel = q[7:0];
         r.row_end = row_end;
         r.frame_end = frame_end;
         pending_pixels.push_back(r);
      endfunction

      // Shift a vertical sum into one lane and emit what it completes
      function void shift_column(int lane, int unsigned v, int unsigned c, bit last_col,
                                 bit final_row);
         if (c == 0) begin
            for (int k = 0; k < 5; k++) window[lane][k] = v;
         end else begin
            for (int k = 0; k < 4; k++) window[lane][k] = window[lane][k+1];
            window[lane][4] = v;
         end
         if (c[0] == 1'b0 && c >= 2)
            emit(window[lane][0], window[lane][1], window[lane][2], window[lane][3],
                 window[lane][4], 1'b0, 1'b0);
         if (last_col) begin
            if (c[0] == 1'b0)
               emit(window[lane][2], window[lane][3], window[lane][4], window[lane][4],
                    window[lane][4], 1'b1, final_row);
            else
               emit(window[lane][1], window[lane][2], window[lane][3], window[lane][4],
                    window[lane][4], 1'b1, final_row);
         end
      endfunction

      function void note_pixel(logic [7:0] pixel);
         int unsigned p, w, h, c, r, ctr, odd;
         int unsigned vsum [2];
         int nv;
         bit last_row, last_col;
         p = pixel;
         w = (frame_width == 0) ? 1 : (frame_width > LINE_DEPTH) ? LINE_DEPTH : frame_width;
         h = (frame_height == 0) ? 1 : (frame_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT
                                                                    : frame_height;
         c = (col_pos >= w) ? 0 : col_pos;
         r = (row_pos >= h) ? 0 : row_pos;
         last_row = (r == h - 1);
         last_col = (c == w - 1);
         nv = 0;
         if (r == 0) begin
            center_line[c] = p;
            partial_line[c] = 5 * p;
            if (last_row) begin
               vsum[nv] = partial_line[c] + 11 * p;
               nv++;
            end
         end else if (r[0] == 1'b0) begin
            ctr = center_line[c];
            odd = odd_line[c];
            vsum[nv] = p + 4 * odd + 6 * ctr + partial_line[c];
            nv++;
            partial_line[c] = ctr + 4 * odd;
            center_line[c] = p;
            if (last_row) begin
               vsum[nv] = partial_line[c] + 11 * p;
               nv++;
            end
         end else begin
            odd_line[c] = p;
            if (last_row) begin
               vsum[nv] = partial_line[c] + 6 * center_line[c] + 5 * p;
               nv++;
            end
         end
         for (int k = 0; k < nv; k++)
            shift_column(k, vsum[k], c, last_col, last_row && (k == nv - 1));
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         col_pos = c;
         row_pos = r;
      endfunction

      function void check_result(logic [7:0] pixel, logic row_end, logic frame_end);
         result_type exp_px;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected beat pixel=%0d row_end=%0b frame_end=%0b",
                     $realtime, pixel, row_end, frame_end);
            mismatches++;
            return;
         end
         exp_px = pending_pixels.pop_front();
         if (pixel !== exp_px.pixel) begin
            $display("%0t: pixel_out expected %0d actual %0d", $realtime, exp_px.pixel, pixel);
            mismatches++;
         end
         if (row_end !== exp_px.row_end) begin
            $display("%0t: last_in_row expected %0b actual %0b", $realtime, exp_px.row_end,
                     row_end);
            mismatches++;
         end
         if (frame_end !== exp_px.frame_end) begin
            $display("%0t: last_in_frame expected %0b actual %0b", $realtime,
                     exp_px.frame_end, frame_end);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_pixel_in;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_pixel_out;
   logic rsp_last_in_row;
   logic rsp_last_in_frame;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   reduce_scoreboard sb = new();
   bit quiet = 1'b0;
   int idle_cycles = 0;
   int stall_left = 0;

   gaussian_pyramid_reduce_5x5_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pixel_out(rsp_pixel_out),
      .rsp_last_in_row(rsp_last_in_row), .rsp_last_in_frame(rsp_last_in_frame),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watch both channels and the register port at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (csr_write_enable) sb.write_reg(csr_index, csr_write_data);
         if (req_valid && !req_stall) sb.note_pixel(req_pixel_in);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_pixel_out, rsp_last_in_row, rsp_last_in_frame);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Hold off the result side in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 6);
      end
      rsp_stall = (stall_left > 0);
   end

   // Offer one pixel, with an occasional gap before it; return at the next falling edge
   task automatic send_pixel(input logic [7:0] p);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_pixel_in = p;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drain all expected beats, then let the pipeline settle
   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                               input logic rnd);
      wait_drained();
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_ROUND_MODE, {12'd0, rnd});
   endtask

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int sent;
      int w, h, count;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_in = '0;
      csr_write_enable = 1'b0;
      csr_index = REG_FRAME_WIDTH;
      csr_write_data = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Odd-size frame with extreme pixels, both flags and interleaved bottom rows
      set_geometry(13'd3, 13'd3, 1'b1);
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd255 : 8'd0);
      // Zero width and height count as one; truncating divide
      set_geometry(13'd0, 13'd0, 1'b0);
      send_pixel(8'd255);
      send_pixel(8'd1);
      // All-white frame with rounding reaches the top value
      set_geometry(13'd4, 13'd2, 1'b1);
      for (int i = 0; i < 8; i++) send_pixel(8'd255);
      // Index past the register list is ignored
      wait_drained();
      write_reg(REG_UNUSED, 13'h1FFF);
      send_pixel(8'd128);
      send_pixel(8'd127);

      // Oversized width clamps to the line depth; start of one row
      set_geometry(13'h1FFF, 13'd1, 1'b0);
      for (int i = 0; i < CLAMP_PIXELS; i++) send_pixel(pick_pixel());
      // Oversized height clamps to the limit, one pixel per row, first rows
      set_geometry(13'd1, 13'h1FFF, 1'b1);
      for (int i = 0; i < CLAMP_PIXELS; i++) send_pixel(pick_pixel());

      // Random frames, mostly small; pause until drained at every change
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         h = $urandom_range(1, 9);
         wait_drained();
         if ($urandom_range(0, 3) != 0) begin
            write_reg(REG_FRAME_WIDTH, 13'(w));
            write_reg(REG_FRAME_HEIGHT, 13'(h));
         end
         write_reg(REG_ROUND_MODE, {12'd0, 1'($urandom_range(0, 1))});
         if (sent > RANDOM_PIXELS * 4 / 5) quiet = 1'b1;
         count = $urandom_range(1, 2 * w * h);
         if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;
         for (int i = 0; i < count; i++) send_pixel(pick_pixel());
         sent += count;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
